/* design/erle_pkg.sv */
// Package for the escape-byte run-length decoder.
// Holds the request and result types, the sequencer encodings and shared constants.
// No dependencies.
package erle_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned REM_W     = 9;
  localparam int unsigned MAX_LANES = 8;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  localparam logic [REM_W-1:0] RUN_BIAS = REM_W'(2);
  localparam logic             REG_ESCAPE = 1'b0;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ESCAPE = 2'd1,
    PH_RUN    = 2'd2
  } erle_phase_e;

  typedef enum logic {
    SEQ_IDLE  = 1'b0,
    SEQ_BURST = 1'b1
  } erle_seq_e;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_in;
    logic              end_of_block;
  } erle_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] lane0;
    logic [BYTE_W-1:0] lane1;
    logic [BYTE_W-1:0] lane2;
    logic [BYTE_W-1:0] lane3;
    logic [BYTE_W-1:0] lane4;
    logic [BYTE_W-1:0] lane5;
    logic [BYTE_W-1:0] lane6;
    logic [BYTE_W-1:0] lane7;
    logic [CNT_W-1:0]  lanes_valid;
    logic              last_of_group;
  } erle_out_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [REM_W-1:0] rest;
    logic             last;
  } erle_chunk_t;

  function automatic erle_out_t erle_build(input logic [BYTE_W-1:0] value,
                                           input logic [CNT_W-1:0]  count,
                                           input logic              last);
    erle_out_t r;
    r.lane0         = (count > CNT_W'(0)) ? value : '0;
    r.lane1         = (count > CNT_W'(1)) ? value : '0;
    r.lane2         = (count > CNT_W'(2)) ? value : '0;
    r.lane3         = (count > CNT_W'(3)) ? value : '0;
    r.lane4         = (count > CNT_W'(4)) ? value : '0;
    r.lane5         = (count > CNT_W'(5)) ? value : '0;
    r.lane6         = (count > CNT_W'(6)) ? value : '0;
    r.lane7         = (count > CNT_W'(7)) ? value : '0;
    r.lanes_valid   = count;
    r.last_of_group = last;
    return r;
  endfunction

endpackage

/* design/erle_regs.sv */
// APB-style configuration register file of the escape-byte run-length decoder.
// Holds the escape byte. Depends on erle_pkg.
module erle_regs
  import erle_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [BYTE_W-1:0] escape_o
);

  logic [BYTE_W-1:0] escape_q, escape_d;
  logic              hit;

  assign pready = 1'b1;
  assign hit    = (paddr[ADDR_W-1] == REG_ESCAPE);

  always_comb begin
    escape_d = escape_q;
    if (psel && penable && pwrite && pready && hit) begin
      escape_d = pwdata[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q <= '0;
    end else begin
      escape_q <= escape_d;
    end
  end

  assign prdata   = hit ? {{(DATA_W-BYTE_W){1'b0}}, escape_q} : '0;
  assign escape_o = escape_q;

endmodule

/* design/erle_chunk.sv */
// Shared compare-and-subtract unit of the escape-byte run-length decoder.
// Splits a remaining byte count into one result's lane count and the rest. Depends on erle_pkg.
module erle_chunk
  import erle_pkg::*;
#(
  parameter int unsigned LANES = 8
) (
  input  logic [REM_W-1:0] rem_i,
  output erle_chunk_t      chunk_o
);

  logic fits;

  assign fits          = (rem_i <= REM_W'(LANES));
  assign chunk_o.count = fits ? rem_i[CNT_W-1:0] : CNT_W'(LANES);
  assign chunk_o.rest  = rem_i - REM_W'(chunk_o.count);
  assign chunk_o.last  = fits;

endmodule

/* design/erle_seq.sv */
// Sequencer of the escape-byte run-length decoder: decode phase, run burst and result register.
// Drives the shared chunk unit. Depends on erle_pkg.
module erle_seq
  import erle_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BYTE_W-1:0] escape_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  erle_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output erle_out_t         out_data_o,
  output logic [REM_W-1:0]  rem_o,
  input  erle_chunk_t       chunk_i
);

  erle_seq_e         seq_q, seq_d;
  erle_phase_e       phase_q, phase_d;
  logic [BYTE_W-1:0] held_q, held_d;
  logic [BYTE_W-1:0] value_q, value_d;
  logic [REM_W-1:0]  remaining_q, remaining_d;
  logic              out_valid_q, out_valid_d;
  erle_out_t         out_data_q;
  logic              can_load, accept, emit;
  logic [BYTE_W-1:0] value_sel;

  assign can_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (seq_q == SEQ_BURST) || !can_load;
  assign accept     = in_valid_i && !in_stall_o;
  assign value_sel  = (seq_q == SEQ_BURST) ? value_q : in_data_i.byte_in;

  always_comb begin
    if (seq_q == SEQ_BURST) begin
      rem_o = remaining_q;
    end else if (phase_q == PH_RUN) begin
      rem_o = {1'b0, held_q} + RUN_BIAS;
    end else begin
      rem_o = REM_W'(1);
    end
  end

  always_comb begin
    seq_d       = seq_q;
    phase_d     = phase_q;
    held_d      = held_q;
    value_d     = value_q;
    remaining_d = remaining_q;
    emit        = 1'b0;
    unique case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          unique case (phase_q)
            PH_ESCAPE: begin
              if (in_data_i.byte_in == escape_i) begin
                emit    = 1'b1;
                phase_d = PH_NORMAL;
              end else begin
                held_d  = in_data_i.byte_in;
                phase_d = PH_RUN;
              end
            end
            PH_RUN: begin
              emit        = 1'b1;
              held_d      = '0;
              phase_d     = PH_NORMAL;
              value_d     = in_data_i.byte_in;
              remaining_d = chunk_i.rest;
              if (!chunk_i.last) begin
                seq_d = SEQ_BURST;
              end
            end
            default: begin
              if (in_data_i.byte_in == escape_i) begin
                phase_d = PH_ESCAPE;
              end else begin
                emit    = 1'b1;
                phase_d = PH_NORMAL;
              end
            end
          endcase
          if (in_data_i.end_of_block) begin
            phase_d = PH_NORMAL;
            held_d  = '0;
          end
        end
      end
      SEQ_BURST: begin
        if (can_load) begin
          emit        = 1'b1;
          remaining_d = chunk_i.rest;
          if (chunk_i.last) begin
            seq_d = SEQ_IDLE;
          end
        end
      end
      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      phase_q     <= PH_NORMAL;
      held_q      <= '0;
      remaining_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      phase_q     <= phase_d;
      held_q      <= held_d;
      remaining_q <= remaining_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    if (emit) begin
      out_data_q <= erle_build(value_sel, chunk_i.count, chunk_i.last);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_burst_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_BURST) |-> in_stall_o)
    else $error("Request accepted during a run burst.");

  a_burst_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_BURST) |-> (remaining_q != '0))
    else $error("Run burst active with nothing left to emit.");

  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.lanes_valid != '0))
    else $error("Result holds no valid lanes.");

  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((seq_q == SEQ_BURST) && emit && chunk_i.last) |=> (seq_q == SEQ_IDLE))
    else $error("Run burst continued past its last result.");

  a_burst_has_phase_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_BURST) |-> (phase_q == PH_NORMAL))
    else $error("Decode phase not normal during a run burst.");
`endif

endmodule

/* design/escape_rle_decoder_unit.sv */
// Escape-byte run-length decoder, top level.
// Literal and escaped-literal requests give one result, valid in the cycle after acceptance.
// A run of count c gives ceil((c+2)/L) results, L the lane count, from the shared chunk unit,
// one per cycle while the output is not stalled; requests are stalled until the last of them
// is loaded. Escape and count bytes give no result. A stalled output holds the block.
// Reset clears the escape byte, decode phase, held count and output valid; no clearing pass.
module escape_rle_decoder_unit
  import erle_pkg::*;
#(
  parameter int unsigned OUT_LANES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  erle_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output erle_out_t         out_data_o
);

  localparam int unsigned LaneCount = (OUT_LANES < 1) ? 1 :
                                      ((OUT_LANES > MAX_LANES) ? MAX_LANES : OUT_LANES);

  logic [BYTE_W-1:0] escape;
  logic [REM_W-1:0]  rem;
  erle_chunk_t       chunk;

  erle_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .escape_o (escape)
  );

  erle_chunk #(
    .LANES (LaneCount)
  ) u_chunk (
    .rem_i   (rem),
    .chunk_o (chunk)
  );

  erle_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .escape_i    (escape),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .rem_o       (rem),
    .chunk_i     (chunk)
  );

endmodule
